// File: hdl/srmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srmd_pkg;

    // Field widths of one record.
    localparam int TIME_WIDTH  = 48;
    localparam int PRICE_WIDTH = 64;
    localparam int AMT_WIDTH   = 64;

    // Default buffer depth of each input stream.
    localparam int FIFO_DEPTH_DEF = 16;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_PUSH_A = 2'd0;
    localparam logic [1:0] OP_PUSH_B = 2'd1;
    localparam logic [1:0] OP_END_A  = 2'd2;
    localparam logic [1:0] OP_END_B  = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]             operation;
        logic [TIME_WIDTH-1:0]  rec_time;
        logic [PRICE_WIDTH-1:0] rec_price;
        logic [AMT_WIDTH-1:0]   rec_amount;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [TIME_WIDTH-1:0]  out_time;
        logic [PRICE_WIDTH-1:0] out_price;
        logic [AMT_WIDTH-1:0]   out_amount;
        logic                   moved;
        logic                   done_res;
        logic                   overflow;
    } out_t;

    // One buffered record as held in a stream buffer.
    typedef struct packed {
        logic [TIME_WIDTH-1:0]  r_time;
        logic [PRICE_WIDTH-1:0] r_price;
        logic [AMT_WIDTH-1:0]   r_amount;
    } rec_t;

    // Merge sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_SELECT,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/srmd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/sorted_record_merge_dedup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An input transaction passes through accept, buffer write and release check (ST_IDLE, ST_APPLY,
// ST_CHECK). Each record it releases, sent or dropped as a repeat, then passes through select and
// pop, dedup and nudge, and check (ST_SELECT, ST_EMIT, ST_CHECK); the done item comes from ST_DONE.
// A new input is taken only once the last one and its records are through; a stalled result port holds it.
// Reset (aresetn low, synchronous): both buffers empty, no stream ended, no previous record.

module sorted_record_merge_dedup_unit #(
    parameter int FIFO_DEPTH = srmd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire srmd_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output srmd_pkg::out_t      m_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int RW = $bits(srmd_pkg::rec_t);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
    localparam logic [srmd_pkg::TIME_WIDTH-1:0] TIME_MAX = '1;
    localparam logic [srmd_pkg::TIME_WIDTH-1:0] TIME_ONE =
        {{(srmd_pkg::TIME_WIDTH-1){1'b0}}, 1'b1};

    srmd_pkg::state_t state_reg, state_next;
    srmd_pkg::in_t    in_reg, in_next;
    srmd_pkg::rec_t   pick_reg, pick_next;
    srmd_pkg::rec_t   prev_reg, prev_next;
    srmd_pkg::out_t   m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;
    logic             have_prev_reg, have_prev_next;
    logic             a_end_reg, a_end_next;
    logic             b_end_reg, b_end_next;
    logic [AW-1:0]    a_head_reg, a_head_next, a_tail_reg, a_tail_next;
    logic [AW-1:0]    b_head_reg, b_head_next, b_tail_reg, b_tail_next;
    logic [CW-1:0]    a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;

    logic             a_we, b_we;
    srmd_pkg::rec_t   wr_rec, a_rd, b_rd;
    logic             out_free;
    logic             a_empty, b_empty;
    logic             is_push, to_a, tgt_end, tgt_full;
    logic             is_dup, is_late;
    logic [srmd_pkg::TIME_WIDTH-1:0] nudge_time;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        ptr_inc = (ptr == PTR_LAST) ? '0 : ptr + AW'(1);
    endfunction

    // Stream buffers; reads always address the current head.
    srmd_ram #(.WIDTH(RW), .DEPTH(FIFO_DEPTH)) u_a_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_tail_reg),
        .wdata (wr_rec),
        .raddr (a_head_reg),
        .rdata (a_rd)
    );

    srmd_ram #(.WIDTH(RW), .DEPTH(FIFO_DEPTH)) u_b_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_tail_reg),
        .wdata (wr_rec),
        .raddr (b_head_reg),
        .rdata (b_rd)
    );

    assign wr_rec.r_time   = in_reg.rec_time;
    assign wr_rec.r_price  = in_reg.rec_price;
    assign wr_rec.r_amount = in_reg.rec_amount;

    assign s_ready  = (state_reg == srmd_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign a_empty  = (a_cnt_reg == '0);
    assign b_empty  = (b_cnt_reg == '0);

    // Decode of the held input transaction.
    assign is_push  = (in_reg.operation == srmd_pkg::OP_PUSH_A) ||
                      (in_reg.operation == srmd_pkg::OP_PUSH_B);
    assign to_a     = (in_reg.operation == srmd_pkg::OP_PUSH_A);
    assign tgt_end  = to_a ? a_end_reg : b_end_reg;
    assign tgt_full = to_a ? (a_cnt_reg == CNT_FULL) : (b_cnt_reg == CNT_FULL);

    // Duplicate and ordering checks against the last emitted record.
    assign is_dup     = have_prev_reg && (pick_reg == prev_reg);
    assign is_late    = have_prev_reg && (pick_reg.r_time <= prev_reg.r_time);
    assign nudge_time = (prev_reg.r_time == TIME_MAX) ? prev_reg.r_time
                                                      : prev_reg.r_time + TIME_ONE;

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srmd_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            a_end_reg     <= 1'b0;
            b_end_reg     <= 1'b0;
            a_head_reg    <= '0;
            a_tail_reg    <= '0;
            a_cnt_reg     <= '0;
            b_head_reg    <= '0;
            b_tail_reg    <= '0;
            b_cnt_reg     <= '0;
            prev_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            have_prev_reg <= have_prev_next;
            a_end_reg     <= a_end_next;
            b_end_reg     <= b_end_next;
            a_head_reg    <= a_head_next;
            a_tail_reg    <= a_tail_next;
            a_cnt_reg     <= a_cnt_next;
            b_head_reg    <= b_head_next;
            b_tail_reg    <= b_tail_next;
            b_cnt_reg     <= b_cnt_next;
            prev_reg      <= prev_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        pick_reg   <= pick_next;
        m_data_reg <= m_data_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        pick_next      = pick_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        a_end_next     = a_end_reg;
        b_end_next     = b_end_reg;
        a_head_next    = a_head_reg;
        a_tail_next    = a_tail_reg;
        a_cnt_next     = a_cnt_reg;
        b_head_next    = b_head_reg;
        b_tail_next    = b_tail_reg;
        b_cnt_next     = b_cnt_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        a_we           = 1'b0;
        b_we           = 1'b0;

        case (state_reg)
            // Wait for the next input transaction.
            srmd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = srmd_pkg::ST_APPLY;
                end
            end

            // Buffer a record, flag an overflow, ignore a push to an ended stream or mark a stream as ended.
            srmd_pkg::ST_APPLY: begin
                if (is_push) begin
                    if (tgt_end) begin
                        state_next = srmd_pkg::ST_CHECK;
                    end else if (tgt_full) begin
                        if (out_free) begin
                            m_data_next          = '0;
                            m_data_next.overflow = 1'b1;
                            m_valid_next         = 1'b1;
                            state_next           = srmd_pkg::ST_CHECK;
                        end
                    end else begin
                        if (to_a) begin
                            a_we        = 1'b1;
                            a_tail_next = ptr_inc(a_tail_reg);
                            a_cnt_next  = a_cnt_reg + CW'(1);
                        end else begin
                            b_we        = 1'b1;
                            b_tail_next = ptr_inc(b_tail_reg);
                            b_cnt_next  = b_cnt_reg + CW'(1);
                        end
                        state_next = srmd_pkg::ST_CHECK;
                    end
                end else begin
                    if (in_reg.operation == srmd_pkg::OP_END_A) begin
                        a_end_next = 1'b1;
                    end else begin
                        b_end_next = 1'b1;
                    end
                    state_next = srmd_pkg::ST_CHECK;
                end
            end

            // Decide whether a record can be released; the head read is in flight.
            srmd_pkg::ST_CHECK: begin
                if ((a_empty && !a_end_reg) || (b_empty && !b_end_reg)) begin
                    state_next = srmd_pkg::ST_IDLE;
                end else if (a_empty && b_empty) begin
                    state_next = srmd_pkg::ST_DONE;
                end else begin
                    state_next = srmd_pkg::ST_SELECT;
                end
            end

            // Pick the earlier head, A on ties, and pop it.
            srmd_pkg::ST_SELECT: begin
                if (a_empty || (!b_empty && (b_rd.r_time < a_rd.r_time))) begin
                    pick_next   = b_rd;
                    b_head_next = ptr_inc(b_head_reg);
                    b_cnt_next  = b_cnt_reg - CW'(1);
                end else begin
                    pick_next   = a_rd;
                    a_head_next = ptr_inc(a_head_reg);
                    a_cnt_next  = a_cnt_reg - CW'(1);
                end
                state_next = srmd_pkg::ST_EMIT;
            end

            // Drop a duplicate, otherwise nudge a late time and send the record.
            srmd_pkg::ST_EMIT: begin
                if (is_dup) begin
                    state_next = srmd_pkg::ST_CHECK;
                end else if (out_free) begin
                    m_data_next            = '0;
                    m_data_next.out_time   = is_late ? nudge_time : pick_reg.r_time;
                    m_data_next.out_price  = pick_reg.r_price;
                    m_data_next.out_amount = pick_reg.r_amount;
                    m_data_next.moved      = is_late;
                    m_valid_next           = 1'b1;
                    prev_next.r_time       = is_late ? nudge_time : pick_reg.r_time;
                    prev_next.r_price      = pick_reg.r_price;
                    prev_next.r_amount     = pick_reg.r_amount;
                    have_prev_next         = 1'b1;
                    state_next             = srmd_pkg::ST_CHECK;
                end
            end

            // Both streams ended and drained: send the done item and start over.
            srmd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_data_next          = '0;
                    m_data_next.done_res = 1'b1;
                    m_valid_next         = 1'b1;
                    a_end_next           = 1'b0;
                    b_end_next           = 1'b0;
                    a_head_next          = '0;
                    a_tail_next          = '0;
                    a_cnt_next           = '0;
                    b_head_next          = '0;
                    b_tail_next          = '0;
                    b_cnt_next           = '0;
                    prev_next            = '0;
                    have_prev_next       = 1'b0;
                    state_next           = srmd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = srmd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: verif/tb_sorted_record_merge_dedup_unit.sv
`timescale 1ns / 1ps

module tb_sorted_record_merge_dedup_unit;

    import srmd_pkg::*;

    localparam int BUF_DEPTH   = FIFO_DEPTH_DEF;
    localparam int RAND_ITEMS  = 380;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 100000;
    localparam int TAIL_CYCLES = 60;
    localparam int TIMEOUT_NS  = 2000000;
    localparam int DIR_ROWS    = 18;

    localparam logic [TIME_WIDTH-1:0] T_MAX = '1;
    localparam out_t NO_RES = '0;

    // One row of the directed table; typed rows carry their single result.
    typedef struct {
        logic [1:0]             op;
        logic [TIME_WIDTH-1:0]  t;
        logic [PRICE_WIDTH-1:0] p;
        logic [AMT_WIDTH-1:0]   a;
        int                     reps;
        bit                     typed;
        out_t                   res;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Merge predictor state.
    rec_t a_pending[$];
    rec_t b_pending[$];
    bit   a_closed;
    bit   b_closed;
    rec_t last_out;
    bit   last_out_valid;
    out_t step_out[$];

    // Results still owed by the block, oldest first.
    out_t due_results[$];
    out_t want_res;

    dir_row_t dir_tab[DIR_ROWS];
    int  fail_count = 0;
    int  items_sent = 0;
    bit  quiet      = 1'b0;
    bit  hold_req   = 1'b0;

    sorted_record_merge_dedup_unit #(
        .FIFO_DEPTH(BUF_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic out_t make_res(input logic [TIME_WIDTH-1:0] t,
                                      input logic [PRICE_WIDTH-1:0] p,
                                      input logic [AMT_WIDTH-1:0] a,
                                      input logic mv, input logic dn, input logic ov);
        out_t r;
        r.out_time   = t;
        r.out_price  = p;
        r.out_amount = a;
        r.moved      = mv;
        r.done_res   = dn;
        r.overflow   = ov;
        return r;
    endfunction

    function automatic void clear_merge();
        a_pending.delete();
        b_pending.delete();
        a_closed       = 1'b0;
        b_closed       = 1'b0;
        last_out       = '0;
        last_out_valid = 1'b0;
    endfunction

    // Drops a repeat of the last record and nudges a late time past it.
    function automatic void emit_merged(input rec_t r);
        rec_t o;
        logic mv;
        o  = r;
        mv = 1'b0;
        if (last_out_valid) begin
            if (r == last_out) return;
            if (r.r_time <= last_out.r_time) begin
                o.r_time = (last_out.r_time == T_MAX) ? T_MAX
                                                      : last_out.r_time + TIME_WIDTH'(1);
                mv = 1'b1;
            end
        end
        last_out       = o;
        last_out_valid = 1'b1;
        step_out.push_back(make_res(o.r_time, o.r_price, o.r_amount, mv, 1'b0, 1'b0));
    endfunction

    // Applies one input transaction and collects the results it releases.
    function automatic void merge_predict(input in_t it);
        rec_t r;
        bit   stop;
        step_out.delete();
        r.r_time   = it.rec_time;
        r.r_price  = it.rec_price;
        r.r_amount = it.rec_amount;
        case (it.operation)
            OP_PUSH_A: begin
                if (!a_closed) begin
                    if (a_pending.size() >= BUF_DEPTH)
                        step_out.push_back(make_res('0, '0, '0, 1'b0, 1'b0, 1'b1));
                    else
                        a_pending.push_back(r);
                end
            end
            OP_PUSH_B: begin
                if (!b_closed) begin
                    if (b_pending.size() >= BUF_DEPTH)
                        step_out.push_back(make_res('0, '0, '0, 1'b0, 1'b0, 1'b1));
                    else
                        b_pending.push_back(r);
                end
            end
            OP_END_A: a_closed = 1'b1;
            OP_END_B: b_closed = 1'b1;
            default: ;
        endcase
        stop = 1'b0;
        while (!stop) begin
            if ((a_pending.size() == 0 && !a_closed) || (b_pending.size() == 0 && !b_closed)) begin
                stop = 1'b1;
            end else if (a_pending.size() == 0 && b_pending.size() == 0) begin
                step_out.push_back(make_res('0, '0, '0, 1'b0, 1'b1, 1'b0));
                clear_merge();
                stop = 1'b1;
            end else if (a_pending.size() == 0) begin
                emit_merged(b_pending.pop_front());
            end else if (b_pending.size() == 0) begin
                emit_merged(a_pending.pop_front());
            end else if (b_pending[0].r_time < a_pending[0].r_time) begin
                emit_merged(b_pending.pop_front());
            end else begin
                emit_merged(a_pending.pop_front());
            end
        end
    endfunction

    function automatic logic [TIME_WIDTH-1:0] rand_time();
        return {16'($urandom), $urandom};
    endfunction

    // Words lean on a few small values so that repeats and near repeats occur.
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [TIME_WIDTH-1:0] time_step();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2, 3, 4, 5: return TIME_WIDTH'($urandom_range(1, 3));
            6, 7, 8: return TIME_WIDTH'($urandom_range(0, 65535));
            default: return rand_time();
        endcase
    endfunction

    function automatic in_t random_item();
        in_t it;
        it.operation  = 2'($urandom);
        it.rec_time   = rand_time();
        it.rec_price  = rand_word();
        it.rec_amount = rand_word();
        return it;
    endfunction

    function automatic void note_fail(input string what, input out_t want, input out_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, what);
            $display("  expected t=%h p=%h a=%h mv=%b done=%b ovf=%b", want.out_time,
                     want.out_price, want.out_amount, want.moved, want.done_res,
                     want.overflow);
            $display("  actual   t=%h p=%h a=%h mv=%b done=%b ovf=%b", got.out_time,
                     got.out_price, got.out_amount, got.moved, got.done_res, got.overflow);
        end
    endfunction

    // Offers one input transaction after a random idle gap and predicts it on acceptance.
    task automatic drive_item(input in_t it, input bit typed, input out_t typed_res);
        bit ignored;
        while (!quiet && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ignored = (it.operation == OP_PUSH_A && a_closed) ||
                  (it.operation == OP_PUSH_B && b_closed);
        merge_predict(it);
        if (typed) begin
            due_results.push_back(typed_res);
        end else begin
            foreach (step_out[i]) due_results.push_back(step_out[i]);
        end
        if (!ignored) items_sent++;
    endtask

    task automatic send_op(input logic [1:0] op);
        in_t it;
        it = random_item();
        it.operation = op;
        drive_item(it, 1'b0, NO_RES);
    endtask

    // One merge session: sorted pushes to both streams (broken ones add stray times and ends), then both end markers.
    task automatic run_session(input bit broken, input int na, input int nb);
        int   ia;
        int   ib;
        int   lean;
        bit   shared;
        bit   to_a;
        bit   a_first;
        logic [TIME_WIDTH:0]   nxt;
        logic [TIME_WIDTH-1:0] ta;
        logic [TIME_WIDTH-1:0] tb;
        logic [TIME_WIDTH-1:0] base;
        in_t  it;
        rec_t prev;
        ia     = 0;
        ib     = 0;
        lean   = $urandom_range(0, 2);
        shared = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = rand_time();
            2: base = T_MAX - TIME_WIDTH'($urandom_range(0, 40));
            default: base = TIME_WIDTH'($urandom_range(0, 1000));
        endcase
        ta   = base;
        tb   = base;
        prev = '{base, 64'd0, 64'd0};
        while (ia < na || ib < nb) begin
            if (ia >= na)
                to_a = 1'b0;
            else if (ib >= nb)
                to_a = 1'b1;
            else if (lean == 0)
                to_a = 1'($urandom_range(0, 1));
            else if (lean == 1)
                to_a = ($urandom_range(0, 9) != 0);
            else
                to_a = ($urandom_range(0, 9) == 0);
            it.operation = to_a ? OP_PUSH_A : OP_PUSH_B;
            if ($urandom_range(0, 4) == 0) begin
                // Exact repeat of the record pushed last.
                it.rec_time   = prev.r_time;
                it.rec_price  = prev.r_price;
                it.rec_amount = prev.r_amount;
            end else begin
                nxt = {1'b0, to_a ? ta : tb} + {1'b0, time_step()};
                it.rec_time   = nxt[TIME_WIDTH] ? T_MAX : nxt[TIME_WIDTH-1:0];
                it.rec_price  = rand_word();
                it.rec_amount = rand_word();
            end
            if (broken && $urandom_range(0, 5) == 0) it.rec_time = rand_time();
            if (broken && $urandom_range(0, 15) == 0)
                it.operation = $urandom_range(0, 1) ? OP_END_A : OP_END_B;
            if (shared) begin
                ta = it.rec_time;
                tb = it.rec_time;
            end else if (to_a) begin
                ta = it.rec_time;
            end else begin
                tb = it.rec_time;
            end
            if (to_a) ia++;
            else ib++;
            prev = '{it.rec_time, it.rec_price, it.rec_amount};
            drive_item(it, 1'b0, NO_RES);
        end
        a_first = 1'($urandom_range(0, 1));
        send_op(a_first ? OP_END_A : OP_END_B);
        if (broken && $urandom_range(0, 1) == 1) begin
            // A push into the closed stream, or the same end marker again.
            if ($urandom_range(0, 1) == 1)
                send_op(a_first ? OP_PUSH_A : OP_PUSH_B);
            else
                send_op(a_first ? OP_END_A : OP_END_B);
        end
        send_op(a_first ? OP_END_B : OP_END_A);
    endtask

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge aclk);
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Each accepted result transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                note_fail("result with no expectation waiting", NO_RES, m_data);
            end else begin
                want_res = due_results.pop_front();
                if (m_data.out_time !== want_res.out_time ||
                    m_data.out_price !== want_res.out_price ||
                    m_data.out_amount !== want_res.out_amount ||
                    m_data.moved !== want_res.moved ||
                    m_data.done_res !== want_res.done_res ||
                    m_data.overflow !== want_res.overflow) begin
                    note_fail("result mismatch", want_res, m_data);
                end
            end
        end
    end

    // Stimulus: reset, directed table, random sessions, then drain.
    initial begin : stimulus
        in_t item;
        int  k;
        int  sel;
        int  wait_cycles;
        clear_merge();
        dir_tab = '{
            '{OP_END_A, '0, '0, '0, 1, 1'b0, NO_RES},
            '{OP_END_B, '0, '0, '0, 1, 1'b1, make_res('0, '0, '0, 1'b0, 1'b1, 1'b0)},
            '{OP_PUSH_A, T_MAX, '1, '1, 1, 1'b0, NO_RES},
            '{OP_PUSH_B, '0, '0, '0, 1, 1'b1, make_res('0, '0, '0, 1'b0, 1'b0, 1'b0)},
            '{OP_END_B, '0, '0, '0, 1, 1'b1, make_res(T_MAX, '1, '1, 1'b0, 1'b0, 1'b0)},
            '{OP_PUSH_B, 48'h123456789ABC, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1,
              1'b0, NO_RES},
            '{OP_PUSH_A, T_MAX, 64'd5, 64'd6, 1, 1'b1,
              make_res(T_MAX, 64'd5, 64'd6, 1'b1, 1'b0, 1'b0)},
            '{OP_PUSH_A, T_MAX, 64'd5, 64'd6, 1, 1'b0, NO_RES},
            '{OP_END_B, '0, '0, '0, 1, 1'b0, NO_RES},
            '{OP_END_A, '0, '0, '0, 1, 1'b1, make_res('0, '0, '0, 1'b0, 1'b1, 1'b0)},
            '{OP_PUSH_A, 48'd100, 64'd1, 64'd1, BUF_DEPTH, 1'b0, NO_RES},
            '{OP_PUSH_A, 48'd200, 64'd7, 64'd7, 1, 1'b1,
              make_res('0, '0, '0, 1'b0, 1'b0, 1'b1)},
            '{OP_PUSH_B, 48'd100, 64'd1, 64'd1, 1, 1'b0, NO_RES},
            '{OP_PUSH_B, 48'd50, 64'd2, 64'd3, 1, 1'b0, NO_RES},
            '{OP_END_B, '0, '0, '0, 1, 1'b0, NO_RES},
            '{OP_PUSH_A, 48'hAAAAAAAAAAAA, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1,
              1'b0, NO_RES},
            '{OP_PUSH_A, 48'h555555555555, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1,
              1'b0, NO_RES},
            '{OP_END_A, '0, '0, '0, 1, 1'b1, make_res('0, '0, '0, 1'b0, 1'b1, 1'b0)}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, ties, repeats, nudges, overflow and done.
        foreach (dir_tab[r]) begin
            for (k = 0; k < dir_tab[r].reps; k++) begin
                item.operation  = dir_tab[r].op;
                item.rec_time   = dir_tab[r].t + TIME_WIDTH'(k);
                item.rec_price  = dir_tab[r].p;
                item.rec_amount = dir_tab[r].a;
                drive_item(item, dir_tab[r].typed, dir_tab[r].res);
            end
        end

        // Random part; the first session runs into a long result hold-off.
        hold_req   = 1'b1;
        run_session(1'b0, 20, 20);
        while (items_sent < RAND_ITEMS) begin
            quiet = (items_sent >= 150 && items_sent < 230);
            sel   = $urandom_range(0, 9);
            if (sel < 7) begin
                run_session(1'b0, $urandom_range(0, 24), $urandom_range(0, 24));
            end else if (sel < 9) begin
                run_session(1'b1, $urandom_range(0, 24), $urandom_range(0, 24));
            end else begin
                repeat ($urandom_range(1, 12)) drive_item(random_item(), 1'b0, NO_RES);
                send_op(OP_END_A);
                send_op(OP_END_B);
            end
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // Wait for every owed result, then keep watching for strays before the verdict.
        wait_cycles = 0;
        while (due_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", due_results.size());
        end
        if (fail_count == 0) begin
            $display("tb_sorted_record_merge_dedup_unit passed");
        end else begin
            $display("tb_sorted_record_merge_dedup_unit failed");
        end
        $finish;
    end

    // Hard limit on the length of the run.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_sorted_record_merge_dedup_unit failed");
        $finish;
    end

endmodule
